// ===== rtl/ade_pkg.sv =====
// ----------------------------------------------------------------------------
// ade_pkg: shared types and constants for the ARM data-processing execute block
// Opcode, condition and shift codes, the unpacked input item and bus widths.
// ----------------------------------------------------------------------------
`default_nettype none

package ade_pkg;

  // Register file depth and data width
  localparam int REG_COUNT   = 16;
  localparam int DATA_W      = 32;

  // Stream word widths (fields packed from bit 0, padded to whole bytes)
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 40;

  // Immediate operand mask and sign bit position
  localparam logic [7:0] IMM_MASK = 8'hff;
  localparam int         TOP_BIT  = 31;

  // Data-processing opcodes; the remaining codes are undefined
  typedef enum logic [3:0] {
    OP_AND = 4'd0,
    OP_EOR = 4'd1,
    OP_SUB = 4'd2,
    OP_RSB = 4'd3,
    OP_ADD = 4'd4,
    OP_TST = 4'd8,
    OP_TEQ = 4'd9,
    OP_CMP = 4'd10,
    OP_ORR = 4'd12,
    OP_MOV = 4'd13
  } alu_op_t;

  // Condition field codes
  typedef enum logic [3:0] {
    COND_EQ = 4'd0,
    COND_NE = 4'd1,
    COND_CS = 4'd2,
    COND_CC = 4'd3,
    COND_MI = 4'd4,
    COND_PL = 4'd5,
    COND_VS = 4'd6,
    COND_VC = 4'd7,
    COND_HI = 4'd8,
    COND_LS = 4'd9,
    COND_GE = 4'd10,
    COND_LT = 4'd11,
    COND_GT = 4'd12,
    COND_LE = 4'd13,
    COND_AL = 4'd14,
    COND_NV = 4'd15
  } cond_t;

  // Barrel shifter types
  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_t;

  // Input item kinds, carried on tuser
  localparam logic KIND_EXEC = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  // One unpacked input item
  typedef struct packed {
    logic        kind;
    logic [3:0]  cond_code;
    logic        imm_flag;
    logic [3:0]  alu_op;
    logic        set_flags;
    logic [3:0]  first_reg;
    logic [3:0]  dest_reg;
    logic [11:0] operand_two;
    logic [31:0] load_value;
  } item_t;

endpackage

`default_nettype wire

// ===== rtl/ade_ram.sv =====
// ----------------------------------------------------------------------------
// ade_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and returns the
// old contents when the same address is written in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ade_ram #(
  parameter int WIDTH = ade_pkg::DATA_W,
  parameter int DEPTH = ade_pkg::REG_COUNT
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/arm_data_processing_execute.sv =====
// ----------------------------------------------------------------------------
// arm_data_processing_execute: ARM data-processing execute stage
// Pipeline: an accepted input word goes through the register-file read into the
//   input register, then through the ALU into the result register, from which
//   its result word leaves.
// Throughput: one word per cycle; input ready follows output ready whenever
//   both the input and the result register hold a word.
// Reset: empties the pipeline, clears N, Z and C, and clears the per-entry
//   valid bits so every register reads as zero until written.
// ----------------------------------------------------------------------------
`default_nettype none

module arm_data_processing_execute #(
  parameter int REG_COUNT = ade_pkg::REG_COUNT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // cond_code[3:0], imm_flag[4], alu_op[8:5], set_flags[9], first_reg[13:10],
  // dest_reg[17:14], operand_two[29:18], load_value[61:30], zero pad[63:62]
  input  wire logic [ade_pkg::IN_TDATA_W-1:0] s_tdata,
  // kind[0]
  input  wire logic                           s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // executed[0], wrote_reg[1], result_value[33:2], flag_neg[34],
  // flag_zero[35], flag_carry[36], zero pad[39:37]
  output logic [ade_pkg::OUT_TDATA_W-1:0]     m_tdata
);

  localparam int AW = $clog2(REG_COUNT);

  // --------------------------------------------------------------------------
  // Helper functions
  // --------------------------------------------------------------------------

  function automatic logic [31:0] rotr(input logic [31:0] v, input logic [4:0] n);
    logic [63:0] w;
    w = {v, v} >> n;
    return w[31:0];
  endfunction

  // Returns {carry_out, value}; amt is the resolved shift amount
  function automatic logic [32:0] barrel(input logic [31:0] v, input logic [1:0] sh,
                                         input logic [7:0] amt, input logic cin);
    logic [32:0] t;
    logic [32:0] r;
    logic [31:0] rr;
    logic [4:0]  a5;
    logic        big;
    logic        exact;
    a5    = amt[4:0];
    big   = |amt[7:5];
    exact = (amt == 8'd32);
    t     = '0;
    rr    = '0;
    if (amt == 8'd0) begin
      r = {cin, v};
    end else begin
      case (ade_pkg::shift_t'(sh))
        ade_pkg::SH_LSL: begin
          if (!big) begin
            t = {1'b0, v} << a5;
            r = t;
          end else begin
            r = {exact ? v[0] : 1'b0, 32'd0};
          end
        end
        ade_pkg::SH_LSR: begin
          if (!big) begin
            t = {v, 1'b0} >> a5;
            r = {t[0], t[32:1]};
          end else begin
            r = {exact ? v[31] : 1'b0, 32'd0};
          end
        end
        ade_pkg::SH_ASR: begin
          if (!big) begin
            t = 33'($signed({v, 1'b0}) >>> a5);
            r = {t[0], t[32:1]};
          end else begin
            r = {v[31], {32{v[31]}}};
          end
        end
        default: begin
          rr = rotr(v, a5);
          r  = {rr[31], rr};
        end
      endcase
    end
    return r;
  endfunction

  function automatic logic cond_pass(input logic [3:0] c, input logic n,
                                     input logic z, input logic cf);
    logic p;
    case (ade_pkg::cond_t'(c))
      ade_pkg::COND_EQ: p = z;
      ade_pkg::COND_NE: p = !z;
      ade_pkg::COND_CS: p = cf;
      ade_pkg::COND_CC: p = !cf;
      ade_pkg::COND_MI: p = n;
      ade_pkg::COND_PL: p = !n;
      ade_pkg::COND_VS: p = 1'b0;
      ade_pkg::COND_VC: p = 1'b1;
      ade_pkg::COND_HI: p = cf && !z;
      ade_pkg::COND_LS: p = !cf || z;
      ade_pkg::COND_GE: p = !n;
      ade_pkg::COND_LT: p = n;
      ade_pkg::COND_GT: p = !z && !n;
      ade_pkg::COND_LE: p = z || n;
      ade_pkg::COND_AL: p = 1'b1;
      default:          p = 1'b0;
    endcase
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Handshake and input unpack
  // --------------------------------------------------------------------------

  ade_pkg::item_t in_item;
  ade_pkg::item_t itm;
  logic           v1;
  logic           out_free;
  logic           adv;
  logic           s_accept;

  assign in_item.kind        = s_tuser;
  assign in_item.cond_code   = s_tdata[3:0];
  assign in_item.imm_flag    = s_tdata[4];
  assign in_item.alu_op      = s_tdata[8:5];
  assign in_item.set_flags   = s_tdata[9];
  assign in_item.first_reg   = s_tdata[13:10];
  assign in_item.dest_reg    = s_tdata[17:14];
  assign in_item.operand_two = s_tdata[29:18];
  assign in_item.load_value  = s_tdata[61:30];

  assign out_free = !m_tvalid || m_tready;
  assign adv      = v1 && out_free;
  assign s_tready = !v1 || out_free;
  assign s_accept = s_tvalid && s_tready;

  // --------------------------------------------------------------------------
  // Register file: three read copies sharing one write, plus valid bits
  // --------------------------------------------------------------------------

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [31:0]          wr_data;
  logic [REG_COUNT-1:0] reg_valid;
  logic [31:0]          q_a;
  logic [31:0]          q_m;
  logic [31:0]          q_s;
  logic                 rv_a;
  logic                 rv_m;
  logic                 rv_s;
  logic                 fwd_valid;
  logic [AW-1:0]        fwd_addr;
  logic [31:0]          fwd_data;

  ade_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_ram_a (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (s_accept),
    .raddr (in_item.first_reg[AW-1:0]),
    .rdata (q_a)
  );

  ade_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_ram_m (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (s_accept),
    .raddr (in_item.operand_two[AW-1:0]),
    .rdata (q_m)
  );

  ade_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_ram_s (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (s_accept),
    .raddr (in_item.operand_two[8 +: AW]),
    .rdata (q_s)
  );

  // Resolve reads: bypass a write that landed with the read, else RAM or zero
  logic [31:0] op_a;
  logic [31:0] op_m;
  logic [31:0] op_s;

  always_comb begin
    if (fwd_valid && fwd_addr == itm.first_reg[AW-1:0]) begin
      op_a = fwd_data;
    end else begin
      op_a = rv_a ? q_a : 32'd0;
    end
    if (fwd_valid && fwd_addr == itm.operand_two[AW-1:0]) begin
      op_m = fwd_data;
    end else begin
      op_m = rv_m ? q_m : 32'd0;
    end
    if (fwd_valid && fwd_addr == itm.operand_two[8 +: AW]) begin
      op_s = fwd_data;
    end else begin
      op_s = rv_s ? q_s : 32'd0;
    end
  end

  // --------------------------------------------------------------------------
  // Operand two
  // --------------------------------------------------------------------------

  logic        neg_bit;
  logic        zero_bit;
  logic        carry_bit;
  logic [32:0] op2_c;
  logic [31:0] op_b;
  logic        sh_c;
  logic [4:0]  imm_rot;
  logic [4:0]  imm_amt;
  logic [31:0] imm_val;

  always_comb begin
    imm_rot = {itm.operand_two[11:8], 1'b0};
    imm_amt = itm.operand_two[11:7];
    imm_val = rotr({24'd0, itm.operand_two[7:0] & ade_pkg::IMM_MASK}, imm_rot);
    if (itm.imm_flag) begin
      op2_c = {(imm_rot != 5'd0) ? imm_val[ade_pkg::TOP_BIT] : carry_bit, imm_val};
    end else if (itm.operand_two[4]) begin
      op2_c = barrel(op_m, itm.operand_two[6:5], op_s[7:0], carry_bit);
    end else if (imm_amt == 5'd0) begin
      case (ade_pkg::shift_t'(itm.operand_two[6:5]))
        ade_pkg::SH_LSL: op2_c = {carry_bit, op_m};
        ade_pkg::SH_ROR: op2_c = {op_m[0], carry_bit, op_m[31:1]};
        default:         op2_c = barrel(op_m, itm.operand_two[6:5], 8'd32, carry_bit);
      endcase
    end else begin
      op2_c = barrel(op_m, itm.operand_two[6:5], {3'd0, imm_amt}, carry_bit);
    end
    op_b = op2_c[31:0];
    sh_c = op2_c[32];
  end

  // --------------------------------------------------------------------------
  // ALU
  // --------------------------------------------------------------------------

  logic        defined;
  logic [31:0] alu_res;
  logic        alu_c;
  logic [32:0] sum33;

  always_comb begin
    defined = 1'b1;
    sum33   = {1'b0, op_a} + {1'b0, op_b};
    alu_res = '0;
    alu_c   = sh_c;
    case (ade_pkg::alu_op_t'(itm.alu_op))
      ade_pkg::OP_AND, ade_pkg::OP_TST: alu_res = op_a & op_b;
      ade_pkg::OP_EOR, ade_pkg::OP_TEQ: alu_res = op_a ^ op_b;
      ade_pkg::OP_ORR:                  alu_res = op_a | op_b;
      ade_pkg::OP_MOV:                  alu_res = op_b;
      ade_pkg::OP_ADD: begin
        alu_res = sum33[31:0];
        alu_c   = sum33[32];
      end
      ade_pkg::OP_SUB, ade_pkg::OP_CMP: begin
        alu_res = op_a - op_b;
        alu_c   = (op_a >= op_b);
      end
      ade_pkg::OP_RSB: begin
        alu_res = op_b - op_a;
        alu_c   = (op_b >= op_a);
      end
      default: defined = 1'b0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Item outcome: executed, write-back and next flags
  // --------------------------------------------------------------------------

  logic        exec_c;
  logic        wrote_c;
  logic [31:0] res_c;
  logic        neg_next;
  logic        zero_next;
  logic        carry_next;

  always_comb begin
    exec_c     = 1'b0;
    wrote_c    = 1'b0;
    res_c      = '0;
    neg_next   = neg_bit;
    zero_next  = zero_bit;
    carry_next = carry_bit;
    if (itm.kind == ade_pkg::KIND_LOAD) begin
      exec_c  = 1'b1;
      wrote_c = 1'b1;
      res_c   = itm.load_value;
    end else if (cond_pass(itm.cond_code, neg_bit, zero_bit, carry_bit) && defined) begin
      exec_c  = 1'b1;
      res_c   = alu_res;
      // Test and compare opcodes do not write back
      wrote_c = (itm.alu_op != ade_pkg::OP_TST) && (itm.alu_op != ade_pkg::OP_TEQ) &&
                (itm.alu_op != ade_pkg::OP_CMP);
      if (itm.set_flags) begin
        neg_next   = alu_res[ade_pkg::TOP_BIT];
        zero_next  = (alu_res == 32'd0);
        carry_next = alu_c;
      end
    end
  end

  assign wr_en   = adv && wrote_c;
  assign wr_addr = itm.dest_reg[AW-1:0];
  assign wr_data = res_c;

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      m_tvalid  <= 1'b0;
      fwd_valid <= 1'b0;
      reg_valid <= '0;
      neg_bit   <= 1'b0;
      zero_bit  <= 1'b0;
      carry_bit <= 1'b0;
    end else begin
      // Advance the input register
      if (s_tready) begin
        v1 <= s_tvalid;
      end
      // Fill or drain the result register
      if (adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      // Commit flags
      if (adv) begin
        neg_bit   <= neg_next;
        zero_bit  <= zero_next;
        carry_bit <= carry_next;
      end
      // Mark written entries
      if (wr_en) begin
        reg_valid[wr_addr] <= 1'b1;
      end
      // Track a write that coincides with the read of the next word
      if (s_accept) begin
        fwd_valid <= wr_en;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------

  always_ff @(posedge clk) begin
    if (s_accept) begin
      itm      <= in_item;
      rv_a     <= reg_valid[in_item.first_reg[AW-1:0]];
      rv_m     <= reg_valid[in_item.operand_two[AW-1:0]];
      rv_s     <= reg_valid[in_item.operand_two[8 +: AW]];
      fwd_addr <= wr_addr;
      fwd_data <= wr_data;
    end
    if (adv) begin
      m_tdata <= {3'd0, carry_next, zero_next, neg_next, res_c, wrote_c, exec_c};
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // A written entry reads as valid from then on
  a_write_marks_valid: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> reg_valid[$past(wr_addr)])
    else $error("register write did not set its valid bit");

  // A word that does not execute leaves the flags alone
  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    (adv && !exec_c) |=> ($stable(neg_bit) && $stable(zero_bit) && $stable(carry_bit)))
    else $error("flags changed on a word that did not execute");

  // A stalled word stays in the input register
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (v1 && !out_free) |=> v1)
    else $error("input register lost a stalled word");

  // A result only appears after a word was in the input register
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(v1))
    else $error("result word without a source word");

endmodule

`default_nettype wire
